### rtl/hptd_pkg.sv
// Shared types, codes and sizing constants for the preorder Huffman tree decoder.
package hptd_pkg;

  // Sizing
  localparam int MAX_LEAVES  = 256;
  localparam int SYMBOL_BITS = 8;
  localparam int NODE_CAP    = 2 * MAX_LEAVES - 1;
  localparam int IDX_W       = $clog2(2 * MAX_LEAVES);
  localparam int CNT_W       = IDX_W + 1;
  localparam int NODE_DEPTH  = 1 << IDX_W;

  localparam logic [IDX_W-1:0] NULL_IDX = '0;
  localparam logic [IDX_W-1:0] ROOT_IDX = IDX_W'(1);

  // Request codes
  localparam logic [1:0] REQ_NODE  = 2'd0;
  localparam logic [1:0] REQ_BIT   = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_INCOMPLETE = 2'd1;
  localparam logic [1:0] ST_OVERFLOW   = 2'd2;
  localparam logic [1:0] ST_ROOT_LEAF  = 2'd3;

  typedef struct packed {
    logic [1:0] req_type;
    logic       shape_bit;
    logic [7:0] leaf_symbol;
    logic       code_bit;
  } in_item_t;

  typedef struct packed {
    logic [7:0] symbol;
    logic [1:0] status;
  } out_item_t;

  // One tree node as held in the node memory
  typedef struct packed {
    logic [IDX_W-1:0]       child_zero;
    logic [IDX_W-1:0]       child_one;
    logic [SYMBOL_BITS-1:0] node_symbol;
    logic [IDX_W-1:0]       node_parent;
    logic [1:0]             slots_filled;
  } node_entry_t;

  localparam int ENTRY_W = $bits(node_entry_t);

  typedef enum logic [2:0] {
    S_IDLE,
    S_NODE_RD,
    S_NODE_WR,
    S_CLIMB,
    S_BIT_RD
  } state_t;

endpackage

### rtl/hptd_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
module hptd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read, holds when not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/huffman_preorder_tree_decoder.sv
// Top level of the preorder Huffman tree decoder: sequencer around the node memory.
//
// Use: send tree-node transactions in preorder (root first) on the in_ channel,
// then code-bit transactions. Each decoded symbol, and each misuse status, comes
// out as one transaction on the out_ channel; stored nodes, internal steps and
// clears give no result. A clear transaction empties the tree and the decoder.
//
// Steps per item (the node memory has a single read port):
//   code bit: one read of the child (child link comes from a cached entry)
//   tree node: read the open parent, write it back with the new child linked,
//              write the new node, then after a leaf climb the full parents
//   root node, clear, errors: handled when taken, with no memory read
// A result sits in the output register from the cycle after its last step and is
// held there while out_stall is high. The output register parts the two sides:
// a new transaction is taken while a result waits, unless the receiver is
// stalling that result at the same time.
//
// Reset (rst_n low, synchronous) empties the tree and returns the walk to the
// root. The node memory is not cleared: every entry is written before it is read.
module huffman_preorder_tree_decoder (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  hptd_pkg::in_item_t in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output hptd_pkg::out_item_t out_data
);

  localparam int IW = hptd_pkg::IDX_W;
  localparam int SW = hptd_pkg::SYMBOL_BITS;
  localparam int CW = hptd_pkg::CNT_W;

  hptd_pkg::state_t state_r, state_nxt;

  logic [CW-1:0] nodes_used_r, nodes_used_nxt;
  logic [IW-1:0] open_parent_r, open_parent_nxt;
  logic          tree_done_r, tree_done_nxt;
  logic [IW-1:0] walk_node_r, walk_node_nxt;
  logic [IW-1:0] walk_c0_r, walk_c0_nxt;
  logic [IW-1:0] walk_c1_r, walk_c1_nxt;
  logic [IW-1:0] root_c0_r, root_c0_nxt;
  logic [IW-1:0] root_c1_r, root_c1_nxt;
  logic          shape_r, shape_nxt;
  logic [SW-1:0] sym_r, sym_nxt;
  logic [IW-1:0] node_r, node_nxt;
  logic [IW-1:0] par_r, par_nxt;
  logic          full_r, full_nxt;
  logic          out_valid_r, out_valid_nxt;
  hptd_pkg::out_item_t out_data_r, out_data_nxt;

  // memory port signals
  logic                  wr_en;
  logic [IW-1:0]         wr_addr;
  hptd_pkg::node_entry_t wr_entry;
  logic                  rd_en;
  logic [IW-1:0]         rd_addr;
  hptd_pkg::node_entry_t rd_entry;

  logic          out_busy;
  logic          in_acc;
  logic          tree_full;
  logic [IW-1:0] cur_c0, cur_c1, next_idx;
  hptd_pkg::node_entry_t upd_entry;

  hptd_ram #(
    .WIDTH (hptd_pkg::ENTRY_W),
    .DEPTH (hptd_pkg::NODE_DEPTH)
  ) u_node_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_entry),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_entry)
  );

  // handshake
  assign out_busy  = out_valid_r && out_stall;
  assign in_stall  = (state_r != hptd_pkg::S_IDLE) || out_busy;
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // walk position: root links live in registers, deeper nodes in the walk cache
  assign tree_full = (nodes_used_r >= CW'(hptd_pkg::NODE_CAP));
  assign cur_c0    = (walk_node_r == hptd_pkg::ROOT_IDX) ? root_c0_r : walk_c0_r;
  assign cur_c1    = (walk_node_r == hptd_pkg::ROOT_IDX) ? root_c1_r : walk_c1_r;
  assign next_idx  = in_data.code_bit ? cur_c1 : cur_c0;

  // open parent with the new node attached in its next free slot
  always_comb begin
    upd_entry = rd_entry;
    if (rd_entry.slots_filled == 2'd0) begin
      upd_entry.child_zero = node_r;
    end else begin
      upd_entry.child_one = node_r;
    end
    upd_entry.slots_filled = rd_entry.slots_filled + 2'd1;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      hptd_pkg::S_IDLE: begin
        if (in_acc) begin
          if (in_data.req_type == hptd_pkg::REQ_NODE) begin
            if (!tree_done_r && !tree_full && nodes_used_r != '0) begin
              state_nxt = hptd_pkg::S_NODE_RD;
            end
          end else if (in_data.req_type == hptd_pkg::REQ_BIT) begin
            if (tree_done_r && next_idx != hptd_pkg::NULL_IDX) begin
              state_nxt = hptd_pkg::S_BIT_RD;
            end
          end
        end
      end
      hptd_pkg::S_NODE_RD: state_nxt = hptd_pkg::S_NODE_WR;
      hptd_pkg::S_NODE_WR: begin
        if (shape_r || !full_r || par_r == hptd_pkg::NULL_IDX) begin
          state_nxt = hptd_pkg::S_IDLE;
        end else begin
          state_nxt = hptd_pkg::S_CLIMB;
        end
      end
      hptd_pkg::S_CLIMB: begin
        if (!rd_entry.slots_filled[1] || rd_entry.node_parent == hptd_pkg::NULL_IDX) begin
          state_nxt = hptd_pkg::S_IDLE;
        end
      end
      hptd_pkg::S_BIT_RD: state_nxt = hptd_pkg::S_IDLE;
      default: state_nxt = hptd_pkg::S_IDLE;
    endcase
  end

  // datapath, memory control and result
  always_comb begin
    nodes_used_nxt  = nodes_used_r;
    open_parent_nxt = open_parent_r;
    tree_done_nxt   = tree_done_r;
    walk_node_nxt   = walk_node_r;
    walk_c0_nxt     = walk_c0_r;
    walk_c1_nxt     = walk_c1_r;
    root_c0_nxt     = root_c0_r;
    root_c1_nxt     = root_c1_r;
    shape_nxt       = shape_r;
    sym_nxt         = sym_r;
    node_nxt        = node_r;
    par_nxt         = par_r;
    full_nxt        = full_r;
    out_valid_nxt   = out_busy;
    out_data_nxt    = out_data_r;
    wr_en           = 1'b0;
    wr_addr         = node_r;
    wr_entry        = '0;
    rd_en           = 1'b0;
    rd_addr         = open_parent_r;

    unique case (state_r)
      hptd_pkg::S_IDLE: begin
        if (in_acc) begin
          case (in_data.req_type)
            hptd_pkg::REQ_NODE: begin
              if (tree_done_r || tree_full) begin
                out_valid_nxt = 1'b1;
                out_data_nxt  = '{symbol: 8'd0, status: hptd_pkg::ST_OVERFLOW};
              end else if (nodes_used_r == '0) begin
                if (!in_data.shape_bit) begin
                  out_valid_nxt = 1'b1;
                  out_data_nxt  = '{symbol: 8'd0, status: hptd_pkg::ST_ROOT_LEAF};
                end else begin
                  // root: fresh entry, both links empty
                  wr_en           = 1'b1;
                  wr_addr         = hptd_pkg::ROOT_IDX;
                  nodes_used_nxt  = CW'(1);
                  open_parent_nxt = hptd_pkg::ROOT_IDX;
                  root_c0_nxt     = hptd_pkg::NULL_IDX;
                  root_c1_nxt     = hptd_pkg::NULL_IDX;
                end
              end else begin
                // fetch the open parent
                rd_en          = 1'b1;
                rd_addr        = open_parent_r;
                node_nxt       = nodes_used_r[IW-1:0] + IW'(1);
                nodes_used_nxt = nodes_used_r + CW'(1);
                shape_nxt      = in_data.shape_bit;
                sym_nxt        = in_data.leaf_symbol[SW-1:0];
              end
            end
            hptd_pkg::REQ_BIT: begin
              if (!tree_done_r) begin
                out_valid_nxt = 1'b1;
                out_data_nxt  = '{symbol: 8'd0, status: hptd_pkg::ST_INCOMPLETE};
              end else if (next_idx == hptd_pkg::NULL_IDX) begin
                walk_node_nxt = hptd_pkg::ROOT_IDX;
              end else begin
                rd_en    = 1'b1;
                rd_addr  = next_idx;
                node_nxt = next_idx;
              end
            end
            hptd_pkg::REQ_CLEAR: begin
              nodes_used_nxt  = '0;
              open_parent_nxt = hptd_pkg::NULL_IDX;
              tree_done_nxt   = 1'b0;
              walk_node_nxt   = hptd_pkg::ROOT_IDX;
            end
            default: ;
          endcase
        end
      end

      hptd_pkg::S_NODE_RD: begin
        // write back the parent with the new child linked
        wr_en    = 1'b1;
        wr_addr  = open_parent_r;
        wr_entry = upd_entry;
        par_nxt  = rd_entry.node_parent;
        full_nxt = upd_entry.slots_filled[1];
        if (open_parent_r == hptd_pkg::ROOT_IDX) begin
          root_c0_nxt = upd_entry.child_zero;
          root_c1_nxt = upd_entry.child_one;
        end
      end

      hptd_pkg::S_NODE_WR: begin
        // write the new node itself
        wr_en                = 1'b1;
        wr_addr              = node_r;
        wr_entry.node_symbol = shape_r ? '0 : sym_r;
        wr_entry.node_parent = open_parent_r;
        if (shape_r) begin
          open_parent_nxt = node_r;
        end else if (full_r) begin
          open_parent_nxt = par_r;
          if (par_r == hptd_pkg::NULL_IDX) begin
            tree_done_nxt = 1'b1;
            walk_node_nxt = hptd_pkg::ROOT_IDX;
          end else begin
            rd_en   = 1'b1;
            rd_addr = par_r;
          end
        end
      end

      hptd_pkg::S_CLIMB: begin
        // climb past parents with both slots filled
        if (rd_entry.slots_filled[1]) begin
          open_parent_nxt = rd_entry.node_parent;
          if (rd_entry.node_parent == hptd_pkg::NULL_IDX) begin
            tree_done_nxt = 1'b1;
            walk_node_nxt = hptd_pkg::ROOT_IDX;
          end else begin
            rd_en   = 1'b1;
            rd_addr = rd_entry.node_parent;
          end
        end
      end

      hptd_pkg::S_BIT_RD: begin
        if (rd_entry.child_zero == hptd_pkg::NULL_IDX &&
            rd_entry.child_one == hptd_pkg::NULL_IDX) begin
          // leaf: emit and restart at the root
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{symbol: 8'(rd_entry.node_symbol), status: hptd_pkg::ST_OK};
          walk_node_nxt = hptd_pkg::ROOT_IDX;
        end else begin
          walk_node_nxt = node_r;
          walk_c0_nxt   = rd_entry.child_zero;
          walk_c1_nxt   = rd_entry.child_one;
        end
      end

      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= hptd_pkg::S_IDLE;
      nodes_used_r  <= '0;
      open_parent_r <= hptd_pkg::NULL_IDX;
      tree_done_r   <= 1'b0;
      walk_node_r   <= hptd_pkg::ROOT_IDX;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      nodes_used_r  <= nodes_used_nxt;
      open_parent_r <= open_parent_nxt;
      tree_done_r   <= tree_done_nxt;
      walk_node_r   <= walk_node_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    walk_c0_r  <= walk_c0_nxt;
    walk_c1_r  <= walk_c1_nxt;
    root_c0_r  <= root_c0_nxt;
    root_c1_r  <= root_c1_nxt;
    shape_r    <= shape_nxt;
    sym_r      <= sym_nxt;
    node_r     <= node_nxt;
    par_r      <= par_nxt;
    full_r     <= full_nxt;
    out_data_r <= out_data_nxt;
  end

  // checks
  a_done_has_nodes: assert property (@(posedge clk) disable iff (!rst_n)
    tree_done_r |-> nodes_used_r != '0)
    else $error("tree marked complete with no nodes");

  a_emit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == hptd_pkg::S_BIT_RD |-> !out_busy)
    else $error("decode step with the result register still held");

  a_done_walk_root: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(tree_done_r) |-> walk_node_r == hptd_pkg::ROOT_IDX)
    else $error("walk not at root when tree completes");

  a_idle_no_parent: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == hptd_pkg::S_IDLE && nodes_used_r != '0 &&
     open_parent_r == hptd_pkg::NULL_IDX) |-> tree_done_r)
    else $error("tree left without open parent but not complete");

endmodule

### dv/tb_huffman_preorder_tree_decoder.sv
// Self-checking testbench for the preorder Huffman tree decoder: tree loading, decoding, misuse.
module tb_huffman_preorder_tree_decoder;
  import hptd_pkg::*;

  localparam logic [1:0] REQ_SPARE     = 2'd3;
  localparam int         CYCLE_LIMIT   = 1_000_000;
  localparam int         SETTLE_CYCLES = 600;
  localparam int         RANDOM_ITEMS  = 200;

  // Shadow of the decoder: node links, build pointer and walk position
  class tree_decode_model;
    logic [IDX_W-1:0]       kid0     [NODE_DEPTH];
    logic [IDX_W-1:0]       kid1     [NODE_DEPTH];
    logic [SYMBOL_BITS-1:0] leaf_sym [NODE_DEPTH];
    logic [IDX_W-1:0]       up_link  [NODE_DEPTH];
    logic [1:0]             fill_cnt [NODE_DEPTH];
    logic [CNT_W-1:0]       node_count;
    logic [IDX_W-1:0]       open_node;
    logic [IDX_W-1:0]       walk_pos;
    bit                     built;
    out_item_t              owed_symbols[$];
    int                     errors;

    function new();
      for (int i = 0; i < NODE_DEPTH; i++) begin
        kid0[i]     = NULL_IDX;
        kid1[i]     = NULL_IDX;
        leaf_sym[i] = '0;
        up_link[i]  = NULL_IDX;
        fill_cnt[i] = '0;
      end
      errors = 0;
      clear_walk();
    endfunction

    function void clear_walk();
      node_count = '0;
      open_node  = NULL_IDX;
      built      = 1'b0;
      walk_pos   = ROOT_IDX;
    endfunction

    function void owe(logic [7:0] sym, logic [1:0] st);
      out_item_t r;
      r.symbol = sym;
      r.status = st;
      owed_symbols = {owed_symbols, r};
    endfunction

    // Work out what one accepted transaction does to the tree and the walk
    function void take_request(in_item_t it);
      logic [IDX_W-1:0] n;
      logic [IDX_W-1:0] p;
      logic [IDX_W-1:0] nxt;
      int               guard;
      case (it.req_type)
        REQ_NODE: begin
          if (built || node_count >= NODE_CAP) begin
            owe(8'h00, ST_OVERFLOW);
            return;
          end
          if (node_count == 0) begin
            if (!it.shape_bit) begin
              owe(8'h00, ST_ROOT_LEAF);
              return;
            end
            kid0[ROOT_IDX]     = NULL_IDX;
            kid1[ROOT_IDX]     = NULL_IDX;
            up_link[ROOT_IDX]  = NULL_IDX;
            fill_cnt[ROOT_IDX] = '0;
            leaf_sym[ROOT_IDX] = '0;
            node_count         = CNT_W'(1);
            open_node          = ROOT_IDX;
            return;
          end
          n = IDX_W'(node_count + 1);
          p = open_node;
          if (fill_cnt[p] == 2'd0) kid0[p] = n;
          else kid1[p] = n;
          fill_cnt[p] = fill_cnt[p] + 2'd1;
          up_link[n]  = p;
          kid0[n]     = NULL_IDX;
          kid1[n]     = NULL_IDX;
          fill_cnt[n] = '0;
          leaf_sym[n] = it.shape_bit ? '0 : it.leaf_symbol[SYMBOL_BITS-1:0];
          node_count  = node_count + 1'b1;
          if (it.shape_bit) begin
            open_node = n;
            return;
          end
          // back up past parents with both children attached
          guard = 0;
          while (open_node != NULL_IDX && fill_cnt[open_node] >= 2'd2 && guard < NODE_DEPTH) begin
            open_node = up_link[open_node];
            guard++;
          end
          if (open_node == NULL_IDX) begin
            built    = 1'b1;
            walk_pos = ROOT_IDX;
          end
        end
        REQ_BIT: begin
          if (!built) begin
            owe(8'h00, ST_INCOMPLETE);
            return;
          end
          nxt = it.code_bit ? kid1[walk_pos] : kid0[walk_pos];
          if (nxt == NULL_IDX) begin
            walk_pos = ROOT_IDX;
          end else if (kid0[nxt] == NULL_IDX && kid1[nxt] == NULL_IDX) begin
            walk_pos = ROOT_IDX;
            owe(8'(leaf_sym[nxt]), ST_OK);
          end else begin
            walk_pos = nxt;
          end
        end
        REQ_CLEAR: clear_walk();
        default: ;
      endcase
    endfunction

    // Compare one accepted result with the oldest owed one
    function void check_output(out_item_t got);
      out_item_t want;
      if (owed_symbols.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual symbol %02h status %0d",
                 $time, got.symbol, got.status);
        errors++;
        return;
      end
      want = owed_symbols.pop_front();
      if (got.symbol !== want.symbol) begin
        $display("%0t: symbol mismatch, expected %02h, actual %02h",
                 $time, want.symbol, got.symbol);
        errors++;
      end
      if (got.status !== want.status) begin
        $display("%0t: status mismatch, expected %0d, actual %0d",
                 $time, want.status, got.status);
        errors++;
      end
    endfunction
  endclass

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  tree_decode_model tree_copy;
  bit               feed_gapless  = 1'b0;
  bit               drain_gapless = 1'b0;
  int               items_sent    = 0;
  int               cycles        = 0;

  huffman_preorder_tree_decoder u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Unused fields of every transaction carry random values
  function automatic in_item_t rand_item(input logic [1:0] req);
    in_item_t it;
    it.req_type    = req;
    it.shape_bit   = 1'($urandom_range(0, 1));
    it.leaf_symbol = 8'($urandom_range(0, 255));
    it.code_bit    = 1'($urandom_range(0, 1));
    return it;
  endfunction

  // Present one transaction after a random gap and wait for it to be taken
  task automatic send_item(input in_item_t it);
    int gap;
    gap = feed_gapless ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    tree_copy.take_request(it);
    if (it.req_type != REQ_SPARE) items_sent++;
  endtask

  task automatic send_node(input logic shape, input logic [7:0] sym);
    in_item_t it;
    it             = rand_item(REQ_NODE);
    it.shape_bit   = shape;
    it.leaf_symbol = sym;
    send_item(it);
  endtask

  task automatic send_bit(input logic b);
    in_item_t it;
    it          = rand_item(REQ_BIT);
    it.code_bit = b;
    send_item(it);
  endtask

  task automatic send_code_bits(input int count);
    repeat (count) send_bit(1'($urandom_range(0, 1)));
  endtask

  // Random full binary tree in preorder; stops early after cut nodes.
  // bias is the percentage chance of an internal node where both shapes fit.
  task automatic send_tree(input int leaves, input int cut, input int bias);
    int   inner_left;
    int   leaf_left;
    int   done_nodes;
    logic shape;
    inner_left = leaves - 1;
    leaf_left  = leaves;
    done_nodes = 0;
    while (leaf_left > 0 && done_nodes < cut) begin
      if (inner_left == 0) shape = 1'b0;
      else if (leaf_left - inner_left == 1) shape = 1'b1;
      else shape = ($urandom_range(0, 99) < bias);
      send_node(shape, 8'($urandom_range(0, 255)));
      if (shape) inner_left--;
      else leaf_left--;
      done_nodes++;
    end
  endtask

  // Result side: random stall before each transaction, with stall-free stretches
  task automatic drain_results();
    int hold;
    forever begin
      if ($urandom_range(0, 15) == 0) drain_gapless = !drain_gapless;
      hold = drain_gapless ? 0 : $urandom_range(0, 11);
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
      tree_copy.check_output(out_data);
    end
  endtask

  // Stimulus
  initial begin
    int base;
    int pick;
    int leaves;
    tree_copy = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    fork
      drain_results();
    join_none

    // directed: misuse on an empty tree, a two-leaf tree, a three-leaf tree
    send_bit(1'b1);                  // walk with no tree
    send_node(1'b0, 8'hFF);          // leaf offered as root
    send_item(rand_item(REQ_SPARE));
    send_node(1'b1, 8'h00);
    send_bit(1'b0);                  // tree still open
    send_node(1'b0, 8'h00);
    send_node(1'b0, 8'hFF);
    send_bit(1'b0);
    send_bit(1'b1);
    send_node(1'b0, 8'h12);          // node after completion
    send_item(rand_item(REQ_CLEAR));
    send_bit(1'b1);
    send_node(1'b1, 8'hFF);
    send_node(1'b0, 8'hAA);
    send_node(1'b1, 8'h00);
    send_node(1'b0, 8'h55);
    send_node(1'b0, 8'h0F);
    send_bit(1'b1);
    send_bit(1'b0);
    send_bit(1'b1);
    send_bit(1'b1);
    send_bit(1'b0);
    send_bit(1'b1);                  // stops on an internal node
    send_item(rand_item(REQ_CLEAR)); // clear mid-walk
    send_bit(1'b0);

    // largest tree, then nodes past it
    send_tree(MAX_LEAVES, 2 * NODE_CAP, 50);
    send_code_bits(60);
    send_node(1'b1, 8'($urandom_range(0, 255)));
    send_node(1'b0, 8'($urandom_range(0, 255)));
    send_item(rand_item(REQ_CLEAR));

    // open tree that runs into the node capacity
    send_tree(MAX_LEAVES + 44, NODE_CAP + 3, 60);
    send_code_bits(3);
    send_item(rand_item(REQ_CLEAR));

    // random scenarios, mostly well-formed trees followed by decoding
    base = items_sent;
    while (items_sent - base < RANDOM_ITEMS) begin
      feed_gapless = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 9);
      if (pick <= 6) begin
        leaves = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 48) : $urandom_range(2, 8);
        send_tree(leaves, 2 * leaves, $urandom_range(20, 80));
        send_code_bits($urandom_range(4, 40));
        if ($urandom_range(0, 3) == 0) begin
          send_item(rand_item($urandom_range(0, 1) ? REQ_NODE : REQ_SPARE));
          send_code_bits($urandom_range(1, 8));
        end
        if ($urandom_range(0, 7) != 0) send_item(rand_item(REQ_CLEAR));
      end else if (pick == 7) begin
        // tree cut short, then bits that find it incomplete
        leaves = $urandom_range(2, 12);
        send_tree(leaves, $urandom_range(1, 2 * leaves - 2), 50);
        send_code_bits($urandom_range(1, 4));
        send_item(rand_item(REQ_CLEAR));
      end else if (pick == 8) begin
        send_item(rand_item(REQ_CLEAR));
        send_node(1'b0, 8'($urandom_range(0, 255)));
        send_code_bits(1);
      end else begin
        repeat ($urandom_range(4, 12)) send_item(rand_item(2'($urandom_range(0, 3))));
      end
    end

    // drain and let any late result show up
    in_valid <= 1'b0;
    while (tree_copy.owed_symbols.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (tree_copy.errors == 0 && tree_copy.owed_symbols.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### files.f
rtl/hptd_pkg.sv
rtl/hptd_ram.sv
rtl/huffman_preorder_tree_decoder.sv
dv/tb_huffman_preorder_tree_decoder.sv
